// ===== design/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg: shared constants and table builder for the scan converter
// register indices, fixed-point widths and the quarter-wave sine generator
// ----------------------------------------------------------------------------
package scp_pkg;

  // configuration register indices
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_ANGLE       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_STEP        = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_RANGE         = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REQUIRE_REMISSION = 2'd3;

  // sine magnitudes in q0.15, 0 .. 32767
  localparam int MAG_BITS  = 15;
  localparam int FRAC_BITS = 15;
  localparam int REMISSION_BITS = 16;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_Q30    = 64'd536870912;
  localparam logic [63:0] MAG_MAX     = 64'd32767;

  // table entry k: sin(pi/2 * k / 2^tbits) by a 13-term taylor series in q30
  function automatic logic [MAG_BITS-1:0] quarter_sine(input int k, input int tbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic signed [63:0] sum;
    logic [63:0]        v;
    int                 n;
    x    = (HALF_PI_Q30 * 64'(k)) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (n = 1; n <= 12; n++) begin
      prod = (term * x2) >> 30;
      case (n)
        1:       term = prod / 6;
        2:       term = prod / 20;
        3:       term = prod / 42;
        4:       term = prod / 72;
        5:       term = prod / 110;
        6:       term = prod / 156;
        7:       term = prod / 210;
        8:       term = prod / 272;
        9:       term = prod / 342;
        10:      term = prod / 420;
        11:      term = prod / 506;
        default: term = prod / 600;
      endcase
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    v = (64'(sum) * MAG_MAX + HALF_Q30) >> 30;
    if (v > MAG_MAX) begin
      v = MAG_MAX;
    end
    return v[MAG_BITS-1:0];
  endfunction

endpackage

// ===== design/scan_polar_to_cartesian.sv =====
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian: laser beam samples to cartesian points
// one beam sample in, zero or one point out, full rate three-stage pipeline
// ----------------------------------------------------------------------------
// usage
//   in_*  : one beam item per handshake, tdata = range_mm, remission;
//           tuser = scan_start, which reloads the angle and clears the index
//   out_* : one point item per kept beam, tdata = point_x, point_y, beam_index
//   cfg_* : register writes by index (start angle, step, max range,
//           remission filter); always ready, write only while idle
// timing
//   one item per cycle while out_tready holds; a kept beam passes the
//   angle, sine table and multiply registers in turn before it shows on
//   out_tvalid; discarded beams advance angle and index, produce no item
// reset
//   synchronous active low; pipeline emptied, angle and index zero,
//   max range all ones, other configuration registers zero
// stall
//   while a result waits unread the whole pipeline holds and in_tready
//   drops; a taken result frees room for a new beam in the same cycle
// ----------------------------------------------------------------------------
module scan_polar_to_cartesian #(
  parameter int ANGLE_BITS      = 16,
  parameter int RANGE_BITS      = 16,
  parameter int SINE_TABLE_BITS = 10,
  parameter int INDEX_BITS      = 12,
  localparam int IN_DATA_BITS  = ((RANGE_BITS + scp_pkg::REMISSION_BITS + 7) / 8) * 8,
  localparam int OUT_FIELDS    = 2 * (RANGE_BITS + 1) + INDEX_BITS,
  localparam int OUT_DATA_BITS = ((OUT_FIELDS + 7) / 8) * 8,
  localparam int CFG_DATA_BITS = (ANGLE_BITS > RANGE_BITS) ? ANGLE_BITS : RANGE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // beam items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // range_mm, remission (lowest bit first)
  input  logic [IN_DATA_BITS-1:0]           in_tdata,
  // scan_start
  input  logic                              in_tuser,
  // point items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // point_x, point_y, beam_index (lowest bit first)
  output logic [OUT_DATA_BITS-1:0]          out_tdata,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]          cfg_data
);

  logic                         adv;
  logic                         in_fire;
  logic [RANGE_BITS-1:0]        range_mm;
  logic [scp_pkg::REMISSION_BITS-1:0] remission;

  // stage 1: angle and index of a kept beam
  logic                         s1_valid;
  logic [ANGLE_BITS-1:0]        s1_angle;
  logic [INDEX_BITS-1:0]        s1_index;
  logic [RANGE_BITS-1:0]        s1_range;

  // stage 2: table magnitudes and quadrant signs
  logic                         s2_valid;
  logic [scp_pkg::MAG_BITS-1:0] cos_mag;
  logic                         cos_neg;
  logic [scp_pkg::MAG_BITS-1:0] sin_mag;
  logic                         sin_neg;
  logic [INDEX_BITS-1:0]        s2_index;
  logic [RANGE_BITS-1:0]        s2_range;

  // output register
  logic [RANGE_BITS:0]          point_x;
  logic [RANGE_BITS:0]          point_y;
  logic [INDEX_BITS-1:0]        beam_index;

  // every stage moves together whenever the output register can take an item
  assign in_tready = adv;
  assign in_fire   = in_tvalid && in_tready;
  assign range_mm  = in_tdata[RANGE_BITS-1:0];
  assign remission = in_tdata[RANGE_BITS +: scp_pkg::REMISSION_BITS];

  scp_beam_seq #(
    .ANGLE_BITS    (ANGLE_BITS),
    .RANGE_BITS    (RANGE_BITS),
    .INDEX_BITS    (INDEX_BITS),
    .CFG_DATA_BITS (CFG_DATA_BITS)
  ) u_beam_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .adv        (adv),
    .in_fire    (in_fire),
    .range_mm   (range_mm),
    .remission  (remission),
    .scan_start (in_tuser),
    .s1_valid   (s1_valid),
    .s1_angle   (s1_angle),
    .s1_index   (s1_index),
    .s1_range   (s1_range)
  );

  scp_sine_rom #(
    .ANGLE_BITS      (ANGLE_BITS),
    .RANGE_BITS      (RANGE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .INDEX_BITS      (INDEX_BITS)
  ) u_sine_rom (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_angle (s1_angle),
    .s1_index (s1_index),
    .s1_range (s1_range),
    .s2_valid (s2_valid),
    .cos_mag  (cos_mag),
    .cos_neg  (cos_neg),
    .sin_mag  (sin_mag),
    .sin_neg  (sin_neg),
    .s2_index (s2_index),
    .s2_range (s2_range)
  );

  scp_scale #(
    .RANGE_BITS (RANGE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_valid   (s2_valid),
    .cos_mag    (cos_mag),
    .cos_neg    (cos_neg),
    .sin_mag    (sin_mag),
    .sin_neg    (sin_neg),
    .s2_index   (s2_index),
    .s2_range   (s2_range),
    .out_ready  (out_tready),
    .adv        (adv),
    .out_valid  (out_tvalid),
    .point_x    (point_x),
    .point_y    (point_y),
    .beam_index (beam_index)
  );

  // fields packed from bit 0 up, zero filled to whole bytes
  assign out_tdata = OUT_DATA_BITS'({beam_index, point_y, point_x});

endmodule

// ===== design/scp_beam_seq.sv =====
// ----------------------------------------------------------------------------
// scp_beam_seq: configuration registers, beam angle and counter
// tracks the running angle and index, filters beams, feeds the first stage
// ----------------------------------------------------------------------------
module scp_beam_seq #(
  parameter int ANGLE_BITS    = 16,
  parameter int RANGE_BITS    = 16,
  parameter int INDEX_BITS    = 12,
  parameter int CFG_DATA_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]          cfg_data,
  input  logic                              adv,
  input  logic                              in_fire,
  input  logic [RANGE_BITS-1:0]             range_mm,
  input  logic [scp_pkg::REMISSION_BITS-1:0] remission,
  input  logic                              scan_start,
  output logic                              s1_valid,
  output logic [ANGLE_BITS-1:0]             s1_angle,
  output logic [INDEX_BITS-1:0]             s1_index,
  output logic [RANGE_BITS-1:0]             s1_range
);

  logic [ANGLE_BITS-1:0] start_angle_r;
  logic [ANGLE_BITS-1:0] angle_step_r;
  logic [RANGE_BITS-1:0] max_range_r;
  logic                  require_rem_r;
  logic [ANGLE_BITS-1:0] beam_angle_r;
  logic [INDEX_BITS-1:0] beam_count_r;
  logic                  s1_valid_r;
  logic [ANGLE_BITS-1:0] s1_angle_r;
  logic [INDEX_BITS-1:0] s1_index_r;
  logic [RANGE_BITS-1:0] s1_range_r;

  logic [ANGLE_BITS-1:0] cur_angle;
  logic [INDEX_BITS-1:0] cur_count;
  logic                  keep;
  logic                  cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
      max_range_r   <= '1;
      require_rem_r <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        scp_pkg::REG_START_ANGLE:       start_angle_r <= cfg_data[ANGLE_BITS-1:0];
        scp_pkg::REG_ANGLE_STEP:        angle_step_r  <= cfg_data[ANGLE_BITS-1:0];
        scp_pkg::REG_MAX_RANGE:         max_range_r   <= cfg_data[RANGE_BITS-1:0];
        scp_pkg::REG_REQUIRE_REMISSION: require_rem_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // scan start reloads the angle and clears the index
  assign cur_angle = scan_start ? start_angle_r : beam_angle_r;
  assign cur_count = scan_start ? '0 : beam_count_r;
  assign keep = (range_mm < max_range_r) && !(require_rem_r && (remission == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_angle_r <= '0;
      beam_count_r <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        beam_angle_r <= cur_angle + angle_step_r;
        beam_count_r <= cur_count + INDEX_BITS'(1);
      end
      if (adv) begin
        s1_valid_r <= in_fire && keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_angle_r <= cur_angle;
      s1_index_r <= cur_count;
      s1_range_r <= range_mm;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_angle = s1_angle_r;
  assign s1_index = s1_index_r;
  assign s1_range = s1_range_r;

endmodule

// ===== design/scp_sine_rom.sv =====
// ----------------------------------------------------------------------------
// scp_sine_rom: quarter-wave sine lookup for sine and cosine lanes
// folds the angle into the quarter table and registers magnitude and sign
// ----------------------------------------------------------------------------
module scp_sine_rom #(
  parameter int ANGLE_BITS      = 16,
  parameter int RANGE_BITS      = 16,
  parameter int SINE_TABLE_BITS = 10,
  parameter int INDEX_BITS      = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         s1_valid,
  input  logic [ANGLE_BITS-1:0]        s1_angle,
  input  logic [INDEX_BITS-1:0]        s1_index,
  input  logic [RANGE_BITS-1:0]        s1_range,
  output logic                         s2_valid,
  output logic [scp_pkg::MAG_BITS-1:0] cos_mag,
  output logic                         cos_neg,
  output logic [scp_pkg::MAG_BITS-1:0] sin_mag,
  output logic                         sin_neg,
  output logic [INDEX_BITS-1:0]        s2_index,
  output logic [RANGE_BITS-1:0]        s2_range
);

  localparam int PHASE_BITS = ANGLE_BITS - 2;
  localparam int SHIFT      = PHASE_BITS - SINE_TABLE_BITS;
  localparam int IDX_BITS   = SINE_TABLE_BITS + 1;
  localparam int TAB_DEPTH  = (1 << SINE_TABLE_BITS) + 1;
  localparam logic [IDX_BITS-1:0] TAB_N = {1'b1, {SINE_TABLE_BITS{1'b0}}};

  logic [scp_pkg::MAG_BITS-1:0] tab [TAB_DEPTH];
  logic [ANGLE_BITS-1:0]        lane_ang [2];
  logic [scp_pkg::MAG_BITS-1:0] mag_r [2];
  logic                         neg_r [2];
  logic                         s2_valid_r;
  logic [INDEX_BITS-1:0]        s2_index_r;
  logic [RANGE_BITS-1:0]        s2_range_r;

  for (genvar k = 0; k < TAB_DEPTH; k++) begin : g_tab
    localparam logic [scp_pkg::MAG_BITS-1:0] ENTRY =
      scp_pkg::quarter_sine(k, SINE_TABLE_BITS);
    assign tab[k] = ENTRY;
  end

  // lane 0 sine, lane 1 cosine (a quarter turn ahead)
  assign lane_ang[0] = s1_angle;
  assign lane_ang[1] = s1_angle + {2'b01, {PHASE_BITS{1'b0}}};

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [1:0]            quad;
    logic [PHASE_BITS-1:0] phase;
    logic [IDX_BITS-1:0]   idx_raw;
    logic [IDX_BITS-1:0]   idx;

    assign quad  = lane_ang[l][ANGLE_BITS-1 -: 2];
    assign phase = lane_ang[l][PHASE_BITS-1:0];

    if (SHIFT > 0) begin : g_drop
      logic [PHASE_BITS:0] rnd;
      assign rnd     = {1'b0, phase} + ((PHASE_BITS + 1)'(1) << (SHIFT - 1));
      assign idx_raw = rnd[PHASE_BITS:SHIFT];
    end else if (SHIFT == 0) begin : g_same
      assign idx_raw = {1'b0, phase};
    end else begin : g_widen
      localparam int PAD = -SHIFT;
      assign idx_raw = {1'b0, phase, {PAD{1'b0}}};
    end

    // odd quadrants run the table backwards
    assign idx = quad[0] ? (TAB_N - idx_raw) : idx_raw;

    always_ff @(posedge clk) begin
      if (adv) begin
        mag_r[l] <= tab[idx];
        neg_r[l] <= quad[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_index_r <= s1_index;
      s2_range_r <= s1_range;
    end
  end

  assign s2_valid = s2_valid_r;
  assign sin_mag  = mag_r[0];
  assign sin_neg  = neg_r[0];
  assign cos_mag  = mag_r[1];
  assign cos_neg  = neg_r[1];
  assign s2_index = s2_index_r;
  assign s2_range = s2_range_r;

endmodule

// ===== design/scp_scale.sv =====
// ----------------------------------------------------------------------------
// scp_scale: range times sine and cosine, rounding and output register
// rounds half away from zero, saturates, holds the item for the receiver
// ----------------------------------------------------------------------------
module scp_scale #(
  parameter int RANGE_BITS = 16,
  parameter int INDEX_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s2_valid,
  input  logic [scp_pkg::MAG_BITS-1:0] cos_mag,
  input  logic                         cos_neg,
  input  logic [scp_pkg::MAG_BITS-1:0] sin_mag,
  input  logic                         sin_neg,
  input  logic [INDEX_BITS-1:0]        s2_index,
  input  logic [RANGE_BITS-1:0]        s2_range,
  input  logic                         out_ready,
  output logic                         adv,
  output logic                         out_valid,
  output logic [RANGE_BITS:0]          point_x,
  output logic [RANGE_BITS:0]          point_y,
  output logic [INDEX_BITS-1:0]        beam_index
);

  localparam int PROD_BITS = RANGE_BITS + scp_pkg::MAG_BITS + 1;

  logic                  out_valid_r;
  logic [RANGE_BITS:0]   point_x_r;
  logic [RANGE_BITS:0]   point_y_r;
  logic [INDEX_BITS-1:0] beam_index_r;

  function automatic logic [RANGE_BITS:0] coord(input logic [RANGE_BITS-1:0] r,
                                                  input logic [scp_pkg::MAG_BITS-1:0] m,
                                                  input logic neg);
    logic [PROD_BITS-1:0] p;
    logic [RANGE_BITS:0]  q;
    logic [RANGE_BITS:0]  s;
    p = PROD_BITS'(r) * PROD_BITS'(m) + (PROD_BITS'(1) << (scp_pkg::FRAC_BITS - 1));
    q = p[PROD_BITS-1:scp_pkg::FRAC_BITS];
    s = q[RANGE_BITS] ? {1'b0, {RANGE_BITS{1'b1}}} : q;
    return neg ? (~s + (RANGE_BITS + 1)'(1)) : s;
  endfunction

  assign adv = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      point_x_r    <= coord(s2_range, cos_mag, cos_neg);
      point_y_r    <= coord(s2_range, sin_mag, sin_neg);
      beam_index_r <= s2_index;
    end
  end

  assign out_valid  = out_valid_r;
  assign point_x    = point_x_r;
  assign point_y    = point_y_r;
  assign beam_index = beam_index_r;

endmodule
